[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mssr_pkg.sv]
`timescale 1ns / 1ps

package mssr_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int CH_W             = 3;
    localparam int PW_W             = 16;
    localparam int TPU_W            = 8;

    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(20);

    // request kinds on the action field
    localparam logic ACT_SET_TARGET = 1'b0;
    localparam logic ACT_TICK       = 1'b1;

    // write request into the channel store
    typedef struct packed {
        logic            set_we;  // store goal and rate
        logic            cur_we;  // store position
        logic [CH_W-1:0] idx;
        logic [PW_W-1:0] goal;
        logic [PW_W-1:0] rate;
        logic [PW_W-1:0] cur;
    } t_chan_wr;

endpackage

[hw/rtl/mssr_slew.sv]
`timescale 1ns / 1ps

// One ramp step toward the goal, clamped at the goal.
module mssr_slew
    import mssr_pkg::*;
(
    input  logic [PW_W-1:0] i_pos,
    input  logic [PW_W-1:0] i_goal,
    input  logic [PW_W-1:0] i_rate,
    output logic [PW_W-1:0] o_next
);

    logic            up;
    logic [PW_W-1:0] gap;
    logic [PW_W-1:0] stepped;

    always_comb begin
        up      = (i_pos <= i_goal);
        gap     = up ? (i_goal - i_pos) : (i_pos - i_goal);
        // only used when rate < gap, so no wrap
        stepped = up ? (i_pos + i_rate) : (i_pos - i_rate);
        o_next  = (i_rate >= gap) ? i_goal : stepped;
    end

endmodule

[hw/rtl/mssr_chan_regs.sv]
`timescale 1ns / 1ps

// Per-channel position, goal and rate registers.
module mssr_chan_regs
    import mssr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chan_wr         i_wr,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [PW_W-1:0]  o_cur,
    output logic [PW_W-1:0]  o_goal,
    output logic [PW_W-1:0]  o_rate
);

    logic [PW_W-1:0] r_cur  [NUM_CHANNELS];
    logic [PW_W-1:0] r_goal [NUM_CHANNELS];
    logic [PW_W-1:0] r_rate [NUM_CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_cur[k]  <= '0;
                r_goal[k] <= '0;
                r_rate[k] <= '0;
            end
        end else begin
            if (i_wr.set_we) begin
                r_goal[i_wr.idx[IDX_W-1:0]] <= i_wr.goal;
                r_rate[i_wr.idx[IDX_W-1:0]] <= i_wr.rate;
            end
            if (i_wr.cur_we) begin
                r_cur[i_wr.idx[IDX_W-1:0]] <= i_wr.cur;
            end
        end
    end

    assign o_cur  = r_cur[i_rd_idx];
    assign o_goal = r_goal[i_rd_idx];
    assign o_rate = r_rate[i_rd_idx];

endmodule

[hw/rtl/multichannel_servo_slew_ramp.sv]
`timescale 1ns / 1ps

// Channel     Direction  Handshake                  Payload
// request     in         start / busy               i_action, i_channel,
//                                                   i_target_width, i_step_rate
// result      out        o_valid (1-cycle strobe)   o_out_channel, o_pulse_width,
//                                                   o_pwm_enabled, o_last
// config      in         i_cfg_valid / o_cfg_ready  i_ticks_per_update
//
// A set-target request finishes in the cycle it is taken; busy stays low and
// its result (if rate is zero and the channel exists) shows in the next cycle.
// An update tick walks the channels through one shared slew unit, one channel
// per cycle, then a flush state; busy is high until the flush is done.
// A tick that is not an update tick finishes in the cycle it is taken.
// Reset is synchronous; the channel store clears in the reset cycle itself.
// Results cannot be stalled; each strobe lasts exactly one cycle.
module multichannel_servo_slew_ramp
    import mssr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // request channel
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [PW_W-1:0]   i_target_width,
    input  logic [PW_W-1:0]   i_step_rate,

    // result channel
    output logic              o_valid,
    output logic [CH_W-1:0]   o_out_channel,
    output logic [PW_W-1:0]   o_pulse_width,
    output logic              o_pwm_enabled,
    output logic              o_last,

    // config channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TPU_W-1:0]  i_ticks_per_update
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,   // one channel per cycle through the slew unit
        S_FLUSH   // emit the held result with the last mark
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic [TPU_W-1:0] r_tick;
    logic [TPU_W-1:0] r_tpu;

    // one-deep hold: a result is only known to be last once the walk ends
    logic             r_pend_vld;
    logic [CH_W-1:0]  r_pend_ch;
    logic [PW_W-1:0]  r_pend_w;

    logic             r_valid;
    logic [CH_W-1:0]  r_ch;
    logic [PW_W-1:0]  r_w;
    logic             r_last;

    t_chan_wr         wr;
    logic [PW_W-1:0]  rd_cur;
    logic [PW_W-1:0]  rd_goal;
    logic [PW_W-1:0]  rd_rate;
    logic [PW_W-1:0]  slew_next;
    logic             rd_moving;
    logic             take;
    logic             ch_ok;
    logic [TPU_W-1:0] tick_inc;

    assign busy        = (r_state != S_IDLE);
    assign take        = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign ch_ok       = ({1'b0, i_channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign tick_inc    = r_tick + TPU_W'(1);
    assign rd_moving   = (rd_cur != rd_goal);

    mssr_chan_regs #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_rd_idx (r_idx),
        .o_cur    (rd_cur),
        .o_goal   (rd_goal),
        .o_rate   (rd_rate)
    );

    mssr_slew u_slew (
        .i_pos  (rd_cur),
        .i_goal (rd_goal),
        .i_rate (rd_rate),
        .o_next (slew_next)
    );

    // Store writes: set-target from idle, position updates during the walk.
    always_comb begin
        wr = '0;
        if (take && (i_action == ACT_SET_TARGET) && ch_ok) begin
            wr.set_we = 1'b1;
            wr.cur_we = (i_step_rate == '0);   // zero rate jumps at once
            wr.idx    = i_channel;
            wr.goal   = i_target_width;
            wr.rate   = i_step_rate;
            wr.cur    = i_target_width;
        end else if ((r_state == S_WALK) && rd_moving) begin
            wr.cur_we = 1'b1;
            wr.idx    = CH_W'(r_idx);
            wr.cur    = slew_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_tick     <= '0;
            r_tpu      <= TPU_RESET;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_valid && o_cfg_ready) begin
                r_tpu <= i_ticks_per_update;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_action == ACT_SET_TARGET) begin
                            if (ch_ok && (i_step_rate == '0)) begin
                                r_valid <= 1'b1;
                                r_ch    <= i_channel;
                                r_w     <= i_target_width;
                                r_last  <= 1'b1;
                            end
                        end else if (tick_inc < r_tpu) begin
                            r_tick <= tick_inc;
                        end else begin
                            // update tick; a period of zero behaves as one
                            r_tick  <= '0;
                            r_idx   <= '0;
                            r_state <= S_WALK;
                        end
                    end
                end

                S_WALK: begin
                    if (rd_moving) begin
                        if (r_pend_vld) begin
                            r_valid <= 1'b1;
                            r_ch    <= r_pend_ch;
                            r_w     <= r_pend_w;
                            r_last  <= 1'b0;
                        end
                        r_pend_vld <= 1'b1;
                        r_pend_ch  <= CH_W'(r_idx);
                        r_pend_w   <= slew_next;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end

                S_FLUSH: begin
                    if (r_pend_vld) begin
                        r_valid <= 1'b1;
                        r_ch    <= r_pend_ch;
                        r_w     <= r_pend_w;
                        r_last  <= 1'b1;
                    end
                    r_pend_vld <= 1'b0;
                    r_state    <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_out_channel = r_ch;
    assign o_pulse_width = r_w;
    assign o_pwm_enabled = (r_w != '0);
    assign o_last        = r_last;

endmodule

[hw/rtl/mssr_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mssr_checker
    import mssr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            busy,
    input logic            o_valid,
    input logic [CH_W-1:0] o_out_channel,
    input logic [PW_W-1:0] o_pulse_width,
    input logic            o_pwm_enabled,
    input logic            o_last
);

    `ASSERT_IMP(a_pwm_en_match, i_clk, i_rst_n, o_valid, o_pwm_enabled == (o_pulse_width != '0), "pwm enable disagrees with width")
    `ASSERT_IMP(a_chan_range, i_clk, i_rst_n, o_valid, o_out_channel <= CH_W'(NUM_CHANNELS - 1), "result channel out of range")
    `ASSERT_NEXT(a_more_after_mid, i_clk, i_rst_n, o_valid && !o_last, o_valid || busy, "run ended without a last mark")
    `ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !o_valid && !busy, "activity right after reset")

endmodule

bind multichannel_servo_slew_ramp mssr_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_out_channel (o_out_channel),
    .o_pulse_width (o_pulse_width),
    .o_pwm_enabled (o_pwm_enabled),
    .o_last        (o_last)
);

[test/multichannel_servo_slew_ramp_test.sv]
`timescale 1ns / 1ps

module multichannel_servo_slew_ramp_test;
    import mssr_pkg::*;

    localparam int NUM_CH = NUM_CHANNELS_DEF;
    localparam int CH_MAX = (1 << CH_W) - 1;

    // one pulse-width update as seen on the result ports
    typedef struct packed {
        logic [CH_W-1:0] chan;
        logic [PW_W-1:0] width;
        logic            enabled;
        logic            last_mark;
    } t_servo_update;

    // Scoreboard: mirrors the per-channel position / goal / rate store and the
    // tick counter, predicts the updates each request causes, and checks the
    // updates the block emits, in order.
    class t_servo_ramp_scoreboard;
        logic [PW_W-1:0]  position [NUM_CH];
        logic [PW_W-1:0]  goal     [NUM_CH];
        logic [PW_W-1:0]  rate     [NUM_CH];
        logic [TPU_W-1:0] tick_ctr;
        logic [TPU_W-1:0] period;
        t_servo_update    pending_q[$];
        int               errors;

        function new();
            for (int i = 0; i < NUM_CH; i++) begin
                position[i] = '0;
                goal[i]     = '0;
                rate[i]     = '0;
            end
            tick_ctr = '0;
            period   = TPU_RESET;
            errors   = 0;
        endfunction

        function void set_period(logic [TPU_W-1:0] value);
            period = value;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Called once per accepted request.
        function void take_request(logic act, logic [CH_W-1:0] ch,
                                   logic [PW_W-1:0] tw, logic [PW_W-1:0] rt);
            int            pos;
            int            tgt;
            int            nxt;
            int            last_ch;
            t_servo_update upd;
            if (act == ACT_SET_TARGET) begin
                if (int'(ch) >= NUM_CH)
                    return;
                rate[ch] = rt;
                goal[ch] = tw;
                // zero rate jumps straight to the goal and reports it
                if (rt == '0) begin
                    position[ch] = tw;
                    upd = '{ch, tw, (tw != '0), 1'b1};
                    pending_q.push_back(upd);
                end
                return;
            end
            tick_ctr = tick_ctr + 8'd1;
            if (tick_ctr < period)
                return;
            tick_ctr = '0;
            // last mover carries the last mark
            last_ch = -1;
            for (int i = 0; i < NUM_CH; i++)
                if (goal[i] != position[i])
                    last_ch = i;
            for (int i = 0; i < NUM_CH; i++) begin
                if (goal[i] != position[i]) begin
                    pos = int'(position[i]);
                    tgt = int'(goal[i]);
                    if (pos > tgt) begin
                        nxt = pos - int'(rate[i]);
                        if (nxt < tgt)
                            nxt = tgt;
                    end else begin
                        nxt = pos + int'(rate[i]);
                        if (nxt > tgt)
                            nxt = tgt;
                    end
                    position[i] = nxt[PW_W-1:0];
                    upd = '{CH_W'(i), position[i], (position[i] != '0), (i == last_ch)};
                    pending_q.push_back(upd);
                end
            end
        endfunction

        function void check_update(logic [CH_W-1:0] ch, logic [PW_W-1:0] pw,
                                   logic en, logic lst);
            t_servo_update exp_upd;
            if (pending_q.size() == 0) begin
                $error("unexpected update: out_channel %0d pulse_width %0d", ch, pw);
                errors++;
                return;
            end
            exp_upd = pending_q.pop_front();
            if (ch !== exp_upd.chan) begin
                $error("out_channel: expected %0d, got %0d", exp_upd.chan, ch);
                errors++;
            end
            if (pw !== exp_upd.width) begin
                $error("pulse_width: expected %0d, got %0d", exp_upd.width, pw);
                errors++;
            end
            if (en !== exp_upd.enabled) begin
                $error("pwm_enabled: expected %0d, got %0d", exp_upd.enabled, en);
                errors++;
            end
            if (lst !== exp_upd.last_mark) begin
                $error("last: expected %0d, got %0d", exp_upd.last_mark, lst);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_action;
    logic [CH_W-1:0]   i_channel;
    logic [PW_W-1:0]   i_target_width;
    logic [PW_W-1:0]   i_step_rate;
    logic              o_valid;
    logic [CH_W-1:0]   o_out_channel;
    logic [PW_W-1:0]   o_pulse_width;
    logic              o_pwm_enabled;
    logic              o_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [TPU_W-1:0]  i_ticks_per_update;

    t_servo_ramp_scoreboard sb = new();

    // sender idling: percent of free cycles in which no request is offered
    int idle_pct;

    multichannel_servo_slew_ramp dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_channel          (i_channel),
        .i_target_width     (i_target_width),
        .i_step_rate        (i_step_rate),
        .o_valid            (o_valid),
        .o_out_channel      (o_out_channel),
        .o_pulse_width      (o_pulse_width),
        .o_pwm_enabled      (o_pwm_enabled),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_ticks_per_update (i_ticks_per_update)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Results are one-cycle strobes; grab each at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_update(o_out_channel, o_pulse_width, o_pwm_enabled, o_last);
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Entered at a falling edge. Leaves start high on return so back-to-back
    // requests never drop it; the caller lowers it when a gap is wanted.
    task automatic send_request(input logic act, input logic [CH_W-1:0] ch,
                                input logic [PW_W-1:0] tw, input logic [PW_W-1:0] rt);
        start          <= 1'b1;
        i_action       <= act;
        i_channel      <= ch;
        i_target_width <= tw;
        i_step_rate    <= rt;
        // busy sampled before the edge updates it
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.take_request(act, ch, tw, rt);
        @(negedge i_clk);
    endtask

    task automatic send_with_gap(input logic act, input logic [CH_W-1:0] ch,
                                 input logic [PW_W-1:0] tw, input logic [PW_W-1:0] rt);
        // each free cycle is idled with the phase's odds
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        send_request(act, ch, tw, rt);
    endtask

    task automatic send_random_request();
        logic            act;
        logic [CH_W-1:0] ch;
        logic [PW_W-1:0] tw;
        logic [PW_W-1:0] rt;
        int              sel;
        act = ($urandom_range(0, 99) < 50) ? ACT_TICK : ACT_SET_TARGET;
        // mostly live channels, some out-of-range ones that must be dropped
        if ($urandom_range(0, 99) < 80)
            ch = CH_W'($urandom_range(0, NUM_CH - 1));
        else
            ch = CH_W'($urandom_range(NUM_CH, CH_MAX));
        tw  = PW_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 3)
            rt = '0;
        else if (sel < 7)
            rt = PW_W'($urandom_range(200, 8000));
        else
            rt = PW_W'($urandom);
        send_with_gap(act, ch, tw, rt);
    endtask

    // Drop start, drain every expected update, then cover a full update walk
    // that may still be running with nothing to report.
    task automatic settle_block();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (NUM_CH + 5) @(negedge i_clk);
    endtask

    task automatic write_period(input logic [TPU_W-1:0] value);
        i_cfg_valid        <= 1'b1;
        i_ticks_per_update <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_period(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly short periods so ramps keep moving; now and then zero or the max.
    function automatic logic [TPU_W-1:0] pick_period();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'd255;
        if (sel == 1)
            return 8'd0;
        return TPU_W'($urandom_range(1, 5));
    endfunction

    initial begin
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_action           = ACT_SET_TARGET;
        i_channel          = '0;
        i_target_width     = '0;
        i_step_rate        = '0;
        i_cfg_valid        = 1'b0;
        i_ticks_per_update = TPU_RESET;
        idle_pct           = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part, period still at its reset value ---
        // immediate jumps: full scale, then zero (pin off)
        send_request(ACT_SET_TARGET, 3'd0, 16'hFFFF, 16'h0000);
        send_request(ACT_SET_TARGET, 3'd5, 16'h0000, 16'h0000);
        // channels past the last one are ignored
        send_request(ACT_SET_TARGET, 3'd6, 16'hFFFF, 16'hFFFF);
        send_request(ACT_SET_TARGET, 3'd7, 16'h1234, 16'h0000);
        // ramps: down in one clamped step, up with clamp on the third, a slow
        // one, and a channel already at its goal
        send_request(ACT_SET_TARGET, 3'd0, 16'h0000, 16'hFFFF);
        send_request(ACT_SET_TARGET, 3'd1, 16'hFFFF, 16'h7FFF);
        send_request(ACT_SET_TARGET, 3'd2, 16'd1500, 16'd400);
        send_request(ACT_SET_TARGET, 3'd3, 16'h0000, 16'h0001);
        // three ticks below the period: counted, nothing reported
        repeat (3) send_request(ACT_TICK, 3'd7, 16'hFFFF, 16'hFFFF);

        // period lowered under the running count: next tick updates
        settle_block();
        write_period(8'd2);
        send_request(ACT_TICK, 3'd0, 16'h0000, 16'h0000);

        // period zero behaves as one; last of these finds every channel settled
        settle_block();
        write_period(8'd0);
        repeat (4) send_request(ACT_TICK, 3'd2, 16'h5A5A, 16'hA5A5);

        // longest period
        settle_block();
        write_period(8'd255);
        send_request(ACT_SET_TARGET, 3'd4, 16'hAAAA, 16'h0000);
        send_request(ACT_SET_TARGET, 3'd4, 16'h5555, 16'h1000);
        send_request(ACT_TICK, 3'd1, 16'h0001, 16'h0001);

        // --- random part: sender idles 16%, then 58%, then not at all ---
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 16 : (phase == 1) ? 58 : 0;
            settle_block();
            write_period((phase == 0) ? 8'd1 : (phase == 1) ? 8'd3 : pick_period());
            for (int k = 0; k < 31; k++) begin
                if (k == 15) begin
                    settle_block();
                    write_period(pick_period());
                end
                send_random_request();
            end
        end

        settle_block();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
